/* rtl/core/cda_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the calendar date arithmetic core.
// No dependencies; every other file in rtl/core imports this package.
package cda_pkg;

	localparam int unsigned TIME_BITS = 38;
	localparam int unsigned DAYS_W    = 22;
	localparam int unsigned SOD_W     = 17;

	localparam logic [TIME_BITS-1:0] TIME_MAX    = '1;
	localparam logic [SOD_W-1:0]     SEC_PER_DAY = 17'd86400;
	localparam logic [SOD_W-1:0]     LAST_SEC    = 17'd86399;

	// Round-up reciprocals: floor(n * R >> k) == n / d for the operand widths used.
	localparam logic [31:0] DAY_RECIP  = 32'(((64'd1 << 41) + 64'd674) / 64'd675);
	localparam logic [17:0] HOUR_RECIP = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
	localparam logic [22:0] ERA_RECIP  = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
	localparam logic [12:0] MIN_RECIP  = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
	localparam logic [18:0] A_RECIP    = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
	localparam logic [18:0] B_RECIP    = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
	localparam logic [18:0] YOE_RECIP  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
	localparam logic [9:0]  CENT_RECIP = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
	localparam logic [11:0] MP_RECIP   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

	typedef enum logic [2:0] {
		OP_ADD         = 3'd0,
		OP_SUB         = 3'd1,
		OP_NEXT_MONTH  = 3'd2,
		OP_MONTH_START = 3'd3,
		OP_MONTH_END   = 3'd4
	} cda_op_t;

	typedef struct packed {
		logic [2:0]           req_type;
		logic [TIME_BITS-1:0] time_seconds;
		logic [31:0]          offset_seconds;
	} cda_req_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] result_seconds;
		logic [13:0]          year;
		logic [3:0]           month;
		logic [4:0]           day;
		logic [4:0]           hour;
		logic [5:0]           minute;
		logic [5:0]           second;
		logic                 leap_year;
		logic                 out_of_range;
	} cda_rsp_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        leap;
	} cda_civil_t;

	typedef struct packed {
		cda_op_t     op;
		logic [31:0] delta;
	} cda_side_t;

	function automatic logic [4:0] cda_days_in(logic [3:0] month, logic leap);
		logic [4:0] len;
		unique case (month)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// Day of a March-based year on which shifted month mp begins.
	function automatic logic [8:0] cda_month_base(logic [3:0] mp);
		logic [8:0] base;
		unique case (mp)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd61;
			4'd3:    base = 9'd92;
			4'd4:    base = 9'd122;
			4'd5:    base = 9'd153;
			4'd6:    base = 9'd184;
			4'd7:    base = 9'd214;
			4'd8:    base = 9'd245;
			4'd9:    base = 9'd275;
			4'd10:   base = 9'd306;
			4'd11:   base = 9'd337;
			default: base = 9'd0;
		endcase
		return base;
	endfunction

endpackage

/* rtl/core/cda_breakdown.sv */
`timescale 1ns / 1ps
// Twelve-stage pipeline that splits epoch seconds into a Gregorian UTC date and time.
// Depends on cda_pkg; carries the time and a sideband word alongside each item.
module cda_breakdown #(
	parameter int unsigned SIDE_W = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [cda_pkg::TIME_BITS-1:0] in_time,
	input  logic [SIDE_W-1:0]            in_side,
	output logic                         out_valid,
	output logic [cda_pkg::TIME_BITS-1:0] out_time,
	output logic [SIDE_W-1:0]            out_side,
	output cda_pkg::cda_civil_t          out_civil,
	output logic [cda_pkg::SOD_W-1:0]    out_sod
);
	import cda_pkg::*;

	localparam int unsigned LAT = 12;

	logic [LAT:1]          vld_s;
	logic [TIME_BITS-1:0]  tm_s   [1:LAT];
	logic [SIDE_W-1:0]     sd_s   [1:LAT];
	logic [DAYS_W-1:0]     days_s1;
	logic [SOD_W-1:0]      sod_s  [2:LAT];
	logic [DAYS_W-1:0]     z_s2, z_s3;
	logic [4:0]            hour_s [3:LAT];
	logic [4:0]            era_s  [3:11];
	logic [11:0]           sih_s4, sih_s5;
	logic [17:0]           doe_s  [4:8];
	logic [5:0]            min_s  [5:LAT];
	logic [6:0]            a_s5;
	logic [2:0]            b_s5;
	logic                  c_s5;
	logic [5:0]            sec_s  [6:LAT];
	logic [17:0]           yp_s6;
	logic [8:0]            yoe_s  [7:10];
	logic [1:0]            cent_s8;
	logic [17:0]           y365_s8;
	logic [8:0]            doy_s  [9:10];
	logic [3:0]            mp_s10;
	logic [4:0]            day_s11, day_s12;
	logic [3:0]            mon_s11, mon_s12;
	logic [8:0]            yoa_s11;
	logic [13:0]           year_s12;
	logic                  leap_s12;

	logic [62:0] day_prod;
	logic [30:0] days675, rem_full;
	logic [34:0] hour_prod;
	logic [44:0] era_prod;
	logic [16:0] hr3600, sih_full;
	logic [21:0] era_days, doe_full;
	logic [24:0] min_prod;
	logic [36:0] a_prod, b_prod, yoe_prod;
	logic [11:0] min60, sec_full;
	logic [17:0] yp_full;
	logic [18:0] cent_prod;
	logic [17:0] y365;
	logic [17:0] doy_full;
	logic [10:0] t5;
	logic [22:0] mp_prod;
	logic [8:0]  day_full;
	logic [13:0] year_full;

	assign day_prod  = 63'(in_time[TIME_BITS-1:7]) * 63'(DAY_RECIP);
	assign days675   = 31'(days_s1) * 31'(10'd675);
	assign rem_full  = 31'(tm_s[1][TIME_BITS-1:7]) - days675;
	assign hour_prod = 35'(sod_s[2]) * 35'(HOUR_RECIP);
	assign era_prod  = 45'(z_s2) * 45'(ERA_RECIP);
	assign hr3600    = 17'(hour_s[3]) * 17'(12'd3600);
	assign sih_full  = sod_s[3] - hr3600;
	assign era_days  = 22'(era_s[3]) * 22'(18'd146097);
	assign doe_full  = z_s3 - era_days;
	assign min_prod  = 25'(sih_s4) * 25'(MIN_RECIP);
	assign a_prod    = 37'(doe_s[4]) * 37'(A_RECIP);
	assign b_prod    = 37'(doe_s[4]) * 37'(B_RECIP);
	assign min60     = 12'(min_s[5]) * 12'(6'd60);
	assign sec_full  = sih_s5 - min60;
	assign yp_full   = doe_s[5] - 18'(a_s5) + 18'(b_s5) - 18'(c_s5);
	assign yoe_prod  = 37'(yp_s6) * 37'(YOE_RECIP);
	assign cent_prod = 19'(yoe_s[7]) * 19'(CENT_RECIP);
	assign y365      = 18'(yoe_s[7]) * 18'(9'd365);
	assign doy_full  = doe_s[8] - (y365_s8 + 18'(yoe_s[8][8:2]) - 18'(cent_s8));
	assign t5        = {doy_s[9], 2'b00} + 11'(doy_s[9]) + 11'd2;
	assign mp_prod   = 23'(t5) * 23'(MP_RECIP);
	assign day_full  = doy_s[10] - cda_month_base(mp_s10) + 9'd1;
	assign year_full = 14'(era_s[11]) * 14'(9'd400) + 14'(yoa_s11);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LAT-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		tm_s[1] <= in_time;
		sd_s[1] <= in_side;
		for (int i = 2; i <= LAT; i++) begin
			tm_s[i] <= tm_s[i-1];
			sd_s[i] <= sd_s[i-1];
		end
		for (int i = 3; i <= LAT; i++) sod_s[i] <= sod_s[i-1];
		for (int i = 4; i <= LAT; i++) hour_s[i] <= hour_s[i-1];
		for (int i = 4; i <= 11; i++) era_s[i] <= era_s[i-1];
		for (int i = 5; i <= 8; i++) doe_s[i] <= doe_s[i-1];
		for (int i = 6; i <= LAT; i++) min_s[i] <= min_s[i-1];
		for (int i = 7; i <= LAT; i++) sec_s[i] <= sec_s[i-1];
		for (int i = 8; i <= 10; i++) yoe_s[i] <= yoe_s[i-1];
		doy_s[10] <= doy_s[9];

		days_s1   <= day_prod[62:41];
		sod_s[2]  <= {rem_full[9:0], tm_s[1][6:0]};
		z_s2      <= days_s1 + 22'd719468;
		hour_s[3] <= hour_prod[33:29];
		era_s[3]  <= era_prod[44:40];
		z_s3      <= z_s2;
		sih_s4    <= sih_full[11:0];
		doe_s[4]  <= doe_full[17:0];
		min_s[5]  <= min_prod[23:18];
		a_s5      <= a_prod[35:29];
		b_s5      <= b_prod[36:34];
		c_s5      <= (doe_s[4] == 18'd146096);
		sih_s5    <= sih_s4;
		sec_s[6]  <= sec_full[5:0];
		yp_s6     <= yp_full;
		yoe_s[7]  <= yoe_prod[35:27];
		cent_s8   <= cent_prod[17:16];
		y365_s8   <= y365;
		doy_s[9]  <= doy_full[8:0];
		mp_s10    <= mp_prod[22:19];
		day_s11   <= day_full[4:0];
		mon_s11   <= (mp_s10 < 4'd10) ? mp_s10 + 4'd3 : mp_s10 - 4'd9;
		yoa_s11   <= yoe_s[10] + 9'((mp_s10 >= 4'd10) ? 1 : 0);
		day_s12   <= day_s11;
		mon_s12   <= mon_s11;
		year_s12  <= year_full;
		leap_s12  <= (yoa_s11[1:0] == 2'b00) && (yoa_s11 != 9'd100) &&
			(yoa_s11 != 9'd200) && (yoa_s11 != 9'd300);
	end

	assign out_valid = vld_s[LAT];
	assign out_time  = tm_s[LAT];
	assign out_side  = sd_s[LAT];
	assign out_sod   = sod_s[LAT];
	assign out_civil = '{
		year:   year_s12,
		month:  mon_s12,
		day:    day_s12,
		hour:   hour_s[LAT],
		minute: min_s[LAT],
		second: sec_s[LAT],
		leap:   leap_s12
	};

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##LAT out_valid)
		else $error("breakdown item lost in pipeline");
	a_sod_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(out_civil.hour) * 32'd3600 + 32'(out_civil.minute) * 32'd60 +
			32'(out_civil.second) == 32'(out_sod)))
		else $error("time of day disagrees with seconds of day");
	a_date_sane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_civil.month >= 4'd1 && out_civil.month <= 4'd12 &&
			out_civil.day >= 5'd1 &&
			out_civil.day <= cda_days_in(out_civil.month, out_civil.leap)))
		else $error("date outside its month");
`endif

endmodule

/* rtl/core/cda_offset.sv */
`timescale 1ns / 1ps
// Three-stage operation unit: builds the offset for the requested operation and applies it
// with saturation. Depends on cda_pkg and on the civil breakdown of the input time.
module cda_offset (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [cda_pkg::TIME_BITS-1:0] in_time,
	input  cda_pkg::cda_side_t            in_side,
	input  cda_pkg::cda_civil_t           in_civil,
	input  logic [cda_pkg::SOD_W-1:0]     in_sod,
	output logic                          out_valid,
	output logic [cda_pkg::TIME_BITS-1:0] out_time,
	output logic                          out_flag
);
	import cda_pkg::*;

	logic [4:0]           cur_len, nxt_len, step;
	logic [3:0]           nxt_mon;
	logic [4:0]           dd;
	logic [SOD_W-1:0]     secs;
	logic                 use_delta, sub;

	logic [3:1]           v_s;
	logic [4:0]           dd_s1;
	logic [SOD_W-1:0]     secs_s1;
	logic                 use_delta_s1, sub_s1, sub_s2;
	logic [31:0]          delta_s1, off_s2;
	logic [TIME_BITS-1:0] tm_s1, tm_s2, r_s3;
	logic                 flag_s3;

	logic [DAYS_W-1:0]    day_secs;
	logic [TIME_BITS:0]   sum, diff;

	assign cur_len = cda_days_in(in_civil.month, in_civil.leap);
	assign nxt_mon = (in_civil.month == 4'd12) ? 4'd1 : in_civil.month + 4'd1;
	assign nxt_len = cda_days_in(nxt_mon, in_civil.leap);
	assign step    = (in_civil.day > nxt_len) ? cur_len - (in_civil.day - nxt_len) : cur_len;

	always_comb begin
		dd        = '0;
		secs      = '0;
		use_delta = 1'b0;
		sub       = 1'b0;
		unique case (in_side.op)
			OP_ADD: begin
				use_delta = 1'b1;
			end
			OP_SUB: begin
				use_delta = 1'b1;
				sub       = 1'b1;
			end
			OP_NEXT_MONTH: begin
				dd = step;
			end
			OP_MONTH_START: begin
				dd   = in_civil.day - 5'd1;
				secs = in_sod;
				sub  = 1'b1;
			end
			OP_MONTH_END: begin
				dd   = cur_len - in_civil.day;
				secs = LAST_SEC - in_sod;
			end
			default: begin
			end
		endcase
	end

	assign day_secs = 22'(dd_s1) * 22'(SEC_PER_DAY);
	assign sum      = {1'b0, tm_s2} + (TIME_BITS+1)'(off_s2);
	assign diff     = {1'b0, tm_s2} - (TIME_BITS+1)'(off_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[2:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		dd_s1        <= dd;
		secs_s1      <= secs;
		use_delta_s1 <= use_delta;
		sub_s1       <= sub;
		delta_s1     <= in_side.delta;
		tm_s1        <= in_time;

		off_s2 <= use_delta_s1 ? delta_s1 : 32'(day_secs + DAYS_W'(secs_s1));
		sub_s2 <= sub_s1;
		tm_s2  <= tm_s1;

		if (sub_s2) begin
			flag_s3 <= diff[TIME_BITS];
			r_s3    <= diff[TIME_BITS] ? '0 : diff[TIME_BITS-1:0];
		end else begin
			flag_s3 <= sum[TIME_BITS];
			r_s3    <= sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
		end
	end

	assign out_valid = v_s[3];
	assign out_time  = r_s3;
	assign out_flag  = flag_s3;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##3 out_valid)
		else $error("operation item lost in pipeline");
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_flag) |-> (out_time == '0 || out_time == TIME_MAX))
		else $error("saturated result not at a range end");
	a_start_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[1] && sub_s1 && !use_delta_s1) |-> ##2 !out_flag)
		else $error("month start saturated");
`endif

endmodule

/* rtl/core/calendar_date_arithmetic_core.sv */
`timescale 1ns / 1ps
// Calendar date arithmetic on UTC epoch seconds: add, subtract, next month, month start and end.
// Depends on cda_pkg, cda_breakdown and cda_offset.
//
// Usage:
//   Request channel: drive req and raise start; the item is taken at a rising edge with
//   start high and busy low. busy stays low, so one item can be taken every cycle.
//   Result channel: done is high for one cycle with rsp holding the new time, its UTC
//   breakdown, the leap-year bit and the saturation flag. Results leave in request order.
//   The path is a 12-stage breakdown of the input time, a 3-stage offset unit and a
//   12-stage breakdown of the result.
//   Throughput: one item per cycle, sustained.
//   The receiver must take each result in its done cycle; nothing is held back.
//   Reset (arst_n low) drops all items in flight and clears every valid bit; data
//   registers are not reset and are ignored until refilled.
//   Request types above month end return the input time unchanged with its breakdown.
module calendar_date_arithmetic_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cda_pkg::cda_req_t req,
	output logic              done,
	output cda_pkg::cda_rsp_t rsp
);
	import cda_pkg::*;

	localparam int unsigned SIDE_W = $bits(cda_side_t);

	logic                 accept;
	cda_side_t            side_in;
	logic                 b1_valid;
	logic [TIME_BITS-1:0] b1_time;
	logic [SIDE_W-1:0]    b1_side;
	cda_civil_t           b1_civil;
	logic [SOD_W-1:0]     b1_sod;
	logic                 op_valid;
	logic [TIME_BITS-1:0] op_time;
	logic                 op_flag;
	logic                 b2_valid;
	logic [TIME_BITS-1:0] b2_time;
	logic [0:0]           b2_side;
	cda_civil_t           b2_civil;
	logic [SOD_W-1:0]     b2_sod;

	assign busy    = 1'b0;
	assign accept  = start & ~busy;
	assign side_in = '{op: cda_op_t'(req.req_type), delta: req.offset_seconds};

	cda_breakdown #(
		.SIDE_W (SIDE_W)
	) u_bd_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_time   (req.time_seconds),
		.in_side   (SIDE_W'(side_in)),
		.out_valid (b1_valid),
		.out_time  (b1_time),
		.out_side  (b1_side),
		.out_civil (b1_civil),
		.out_sod   (b1_sod)
	);

	cda_offset u_offset (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (b1_valid),
		.in_time   (b1_time),
		.in_side   (cda_side_t'(b1_side)),
		.in_civil  (b1_civil),
		.in_sod    (b1_sod),
		.out_valid (op_valid),
		.out_time  (op_time),
		.out_flag  (op_flag)
	);

	cda_breakdown #(
		.SIDE_W (1)
	) u_bd_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (op_valid),
		.in_time   (op_time),
		.in_side   (op_flag),
		.out_valid (b2_valid),
		.out_time  (b2_time),
		.out_side  (b2_side),
		.out_civil (b2_civil),
		.out_sod   (b2_sod)
	);

	assign done = b2_valid;
	assign rsp  = '{
		result_seconds: b2_time,
		year:           b2_civil.year,
		month:          b2_civil.month,
		day:            b2_civil.day,
		hour:           b2_civil.hour,
		minute:         b2_civil.minute,
		second:         b2_civil.second,
		leap_year:      b2_civil.leap,
		out_of_range:   b2_side[0]
	};

`ifndef SYNTHESIS
	a_end_to_end: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##27 done)
		else $error("item lost between request and result");
	a_sod_end: assert property (@(posedge clk) disable iff (!arst_n)
		(done && b2_civil.hour == 5'd23 && b2_civil.minute == 6'd59 &&
			b2_civil.second == 6'd59) |-> (b2_sod == LAST_SEC))
		else $error("last second of day misreported");
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.out_of_range && rsp.result_seconds != '0) |->
			(rsp.result_seconds == TIME_MAX))
		else $error("saturated result not at maximum");
`endif

endmodule
